FILE: rtl/core/svm_pkg.sv
// Package for the stack machine execute block: types, opcodes, status codes.
// No dependencies; used by every file under rtl/core except svm_if and svm_div.
package svm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 2048;
  localparam logic [31:0] FRAME_WORDS = 32'd5;

  typedef enum logic [3:0] {
    OP_LIT = 4'd0, OP_LOD = 4'd1, OP_STO = 4'd2, OP_MVX = 4'd3,
    OP_OPR = 4'd4, OP_INT = 4'd5, OP_CAL = 4'd6, OP_RTN = 4'd7,
    OP_JMP = 4'd8, OP_JPC = 4'd9, OP_GET = 4'd10, OP_PUT = 4'd11
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ILL_OPC = 3'd1, ST_ILL_OPR = 3'd2,
    ST_DIV_ZERO = 3'd3, ST_RANGE = 3'd4
  } status_t;

  localparam logic [31:0] OPR_NEG = 32'd0, OPR_ADD = 32'd1, OPR_SUB = 32'd2,
    OPR_MUL = 32'd3, OPR_DIV = 32'd4, OPR_EQ = 32'd5, OPR_NE = 32'd6,
    OPR_LT = 32'd7, OPR_LE = 32'd8, OPR_GT = 32'd9, OPR_GE = 32'd10;

  localparam logic [2:0] SEL_PC = 3'd0, SEL_FB = 3'd1, SEL_SP = 3'd2,
    SEL_X3 = 3'd3, SEL_X4 = 3'd4;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  base_sel;
    logic [2:0]  index_sel;
    logic [31:0] operand;
    logic [31:0] get_value;
    logic        legal;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        put_valid;
    logic [31:0] put_value;
    logic [31:0] top_value;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [3:0] {
    EX_IDLE, EX_CLEAR, EX_RD1, EX_RD2, EX_RD3, EX_RD4, EX_CALC, EX_DIV,
    EX_WR, EX_WR2, EX_WR3, EX_WR4, EX_TOP, EX_TOPW, EX_OUT
  } ex_state_t;

endpackage

FILE: rtl/core/svm_if.sv
// Valid/ready channel interfaces for instructions and results.
// No dependencies.
interface svm_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        opcode;
  logic [2:0]        base_sel;
  logic [2:0]        index_sel;
  logic signed [31:0] operand;
  logic signed [31:0] get_value;
  modport source (output valid, opcode, base_sel, index_sel, operand, get_value,
                  input ready);
  modport sink (input valid, opcode, base_sel, index_sel, operand, get_value,
                output ready);
endinterface

interface svm_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] next_pc;
  logic              put_valid;
  logic signed [31:0] put_value;
  logic signed [31:0] top_value;
  logic [2:0]        status;
  modport source (output valid, next_pc, put_valid, put_value, top_value, status,
                  input ready);
  modport sink (input valid, next_pc, put_valid, put_value, top_value, status,
                output ready);
endinterface

FILE: rtl/core/stack_vm_instruction_execute_top.sv
// Channel      | Dir | Payload
// in_ch        | in  | opcode, base_sel, index_sel, operand, get_value
// out_ch       | out | next_pc, put_valid, put_value, top_value, status
// An instruction steps through the back-end sequencer states in order, paced by the single
// stack memory port (one word a cycle); division also waits on the bit-serial divider.
// After reset the stack memory is cleared word by word before execution starts;
// instructions are still taken into the two-entry queue meanwhile.
// A held result stalls the sequencer; the queue keeps taking instructions until full.
// Depends on svm_pkg, svm_if, svm_front, svm_back and svm_div.
module stack_vm_instruction_execute_top #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  svm_in_if.sink   in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;

  instr_t  q_data;
  logic    q_valid, q_pop;
  result_t res;

  svm_front u_front (.clk, .rst, .in_ch, .q_data, .q_valid, .q_pop);

  svm_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_pop, .res, .res_valid(out_ch.valid),
    .res_ready(out_ch.ready)
  );

  assign out_ch.next_pc   = res.next_pc;
  assign out_ch.put_valid = res.put_valid;
  assign out_ch.put_value = res.put_value;
  assign out_ch.top_value = res.top_value;
  assign out_ch.status    = res.status;
endmodule

FILE: rtl/core/svm_front.sv
// Front end: accepts instructions, flags illegal opcodes, feeds a two-entry queue.
// Depends on svm_pkg and svm_in_if.
module svm_front (
  input  logic         clk,
  input  logic         rst,
  svm_in_if.sink       in_ch,
  output svm_pkg::instr_t q_data,
  output logic         q_valid,
  input  logic         q_pop
);
  import svm_pkg::*;

  instr_t      slot [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  instr_t      ins;
  logic        push;

  always_comb begin
    ins.opcode    = in_ch.opcode;
    ins.base_sel  = in_ch.base_sel;
    ins.index_sel = in_ch.index_sel;
    ins.operand   = in_ch.operand;
    ins.get_value = in_ch.get_value;
    ins.legal     = in_ch.opcode <= OP_PUT;
  end

  assign in_ch.ready = count != 2'd2;
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = count != 2'd0;
  assign q_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= ins;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

FILE: rtl/core/svm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing beyond its ports.
module svm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem[30:0], quo[31]} - {1'b0, dvs};
  assign quotient = neg ? 32'd0 - quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= 32'd0;
        quo  <= dividend[31] ? 32'd0 - dividend : dividend;
        dvs  <= divisor[31] ? 32'd0 - divisor : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/core/svm_back.sv
// Back end: register file, stack memory, sequencer that executes one instruction.
// Depends on svm_pkg and svm_div.
module svm_back #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  svm_pkg::instr_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  output svm_pkg::result_t res,
  output logic            res_valid,
  input  logic            res_ready
);
  import svm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic [AW-1:0] raddr, waddr, clr_addr;
  logic [31:0] wdata;
  logic        we;

  logic [31:0] pc, fb, sp, x3, x4;
  ex_state_t   state, state_next;
  instr_t      cur;
  logic [31:0] w0, w1, w2, addr, calc;
  logic [2:0]  st;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        out_full;
  logic        err;

  function automatic logic ok(input logic [31:0] a);
    return a < 32'(STACK_DEPTH);
  endfunction

  function automatic logic [31:0] regv(input logic [2:0] s, input logic [31:0] f,
      input logic [31:0] p, input logic [31:0] a, input logic [31:0] b);
    case (s)
      SEL_FB:  return f;
      SEL_SP:  return p;
      SEL_X3:  return a;
      SEL_X4:  return b;
      default: return 32'd0;
    endcase
  endfunction

  svm_div u_div (
    .clk, .rst, .start(div_start), .dividend(w1), .divisor(w0),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Early error check and address, valid once an instruction is latched.
  always_comb begin
    addr = 32'd0;
    err  = 1'b0;
    st   = ST_OK;
    case (cur.opcode)
      OP_LIT, OP_GET: if (!ok(sp + 32'd1)) st = ST_RANGE;
      OP_LOD: begin
        addr = (cur.base_sel == SEL_SP ? sp + 32'd1 : regv(cur.base_sel, fb, sp, x3, x4))
             + (cur.index_sel == SEL_SP ? sp + 32'd1 : regv(cur.index_sel, fb, sp, x3, x4))
             + cur.operand;
        if (!ok(sp + 32'd1) || !ok(addr)) st = ST_RANGE;
      end
      OP_STO: begin
        addr = regv(cur.base_sel, fb, sp, x3, x4) + regv(cur.index_sel, fb, sp, x3, x4)
             + cur.operand;
        if (!ok(sp) || !ok(addr)) st = ST_RANGE;
      end
      OP_MVX, OP_JPC, OP_PUT: if (!ok(sp)) st = ST_RANGE;
      OP_OPR: begin
        if (cur.operand > OPR_GE) st = ST_ILL_OPR;
        else if (cur.operand == OPR_NEG) begin
          if (!ok(sp)) st = ST_RANGE;
        end else if (!ok(sp) || !ok(sp - 32'd1)) st = ST_RANGE;
      end
      OP_CAL: if (!ok(sp + 32'd1) || !ok(sp + 32'd2) || !ok(sp + 32'd3) ||
                  !ok(sp + 32'd4)) st = ST_RANGE;
      OP_RTN: if (!ok(fb - 32'd4) || !ok(fb - 32'd3) || !ok(fb - 32'd2) ||
                  !ok(fb - 32'd1)) st = ST_RANGE;
      OP_INT, OP_JMP: st = ST_OK;
      default: st = ST_ILL_OPC;
    endcase
    err = st != ST_OK;
  end

  always_comb begin
    calc = 32'd0;
    case (cur.operand)
      OPR_ADD: calc = w1 + w0;
      OPR_SUB: calc = w1 - w0;
      OPR_MUL: calc = w1 * w0;
      OPR_DIV: calc = div_q;
      OPR_EQ:  calc = 32'($signed(w1) == $signed(w0));
      OPR_NE:  calc = 32'($signed(w1) != $signed(w0));
      OPR_LT:  calc = 32'($signed(w1) <  $signed(w0));
      OPR_LE:  calc = 32'($signed(w1) <= $signed(w0));
      OPR_GT:  calc = 32'($signed(w1) >  $signed(w0));
      OPR_GE:  calc = 32'($signed(w1) >= $signed(w0));
      default: calc = 32'd0 - w0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      EX_CLEAR: if (clr_addr == AW'(STACK_DEPTH - 1)) state_next = EX_IDLE;
      EX_IDLE:  if (q_valid && !out_full) state_next = EX_RD1;
      EX_RD1: begin
        if (err) state_next = EX_TOP;
        else case (cur.opcode)
          OP_LIT, OP_GET, OP_INT, OP_JMP: state_next = EX_WR;
          default: state_next = EX_RD2;
        endcase
      end
      EX_RD2: begin
        case (cur.opcode)
          OP_OPR: state_next = (cur.operand == OPR_NEG) ? EX_WR : EX_RD3;
          OP_RTN: state_next = EX_RD3;
          default: state_next = EX_WR;
        endcase
      end
      EX_RD3: state_next = (cur.opcode == OP_RTN) ? EX_RD4 : EX_CALC;
      EX_RD4: state_next = EX_WR;
      EX_CALC: begin
        if (cur.operand == OPR_DIV) state_next = (w0 == 32'd0) ? EX_TOP : EX_DIV;
        else state_next = EX_WR;
      end
      EX_DIV:  if (div_done) state_next = EX_WR;
      EX_WR:   state_next = (cur.opcode == OP_CAL) ? EX_WR2 : EX_TOP;
      EX_WR2:  state_next = EX_WR3;
      EX_WR3:  state_next = EX_WR4;
      EX_WR4:  state_next = EX_TOP;
      EX_TOP:  state_next = EX_TOPW;
      EX_TOPW: state_next = EX_OUT;
      EX_OUT:  state_next = EX_IDLE;
      default: state_next = EX_IDLE;
    endcase
  end

  // Memory address, write and control outputs.
  always_comb begin
    raddr = AW'(sp);
    we    = 1'b0;
    waddr = AW'(sp);
    wdata = 32'd0;
    q_pop = 1'b0;
    div_start = 1'b0;
    case (state)
      EX_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
      end
      EX_IDLE: q_pop = q_valid && !out_full;
      EX_RD1: begin
        case (cur.opcode)
          OP_LOD: raddr = AW'(addr);
          OP_RTN: raddr = AW'(fb - 32'd4);
          default: raddr = AW'(sp);
        endcase
      end
      EX_RD2: raddr = (cur.opcode == OP_RTN) ? AW'(fb - 32'd3) : AW'(sp - 32'd1);
      EX_RD3: raddr = AW'(fb - 32'd2);
      EX_RD4: raddr = AW'(fb - 32'd1);
      EX_CALC: div_start = cur.operand == OPR_DIV && w0 != 32'd0;
      EX_WR: begin
        case (cur.opcode)
          OP_LIT: begin we = 1'b1; waddr = AW'(sp + 32'd1); wdata = cur.operand; end
          OP_GET: begin we = 1'b1; waddr = AW'(sp + 32'd1); wdata = cur.get_value; end
          OP_LOD: begin we = 1'b1; waddr = AW'(sp + 32'd1); wdata = w0; end
          OP_STO: begin we = 1'b1; waddr = AW'(addr); wdata = w0; end
          OP_OPR: begin
            we = 1'b1;
            waddr = (cur.operand == OPR_NEG) ? AW'(sp) : AW'(sp - 32'd1);
            wdata = calc;
          end
          OP_CAL: begin we = 1'b1; waddr = AW'(sp + 32'd1); wdata = fb; end
          default: we = 1'b0;
        endcase
      end
      // The program counter has already been advanced in the first write cycle.
      EX_WR2: begin we = 1'b1; waddr = AW'(sp + 32'd2); wdata = pc; end
      EX_WR3: begin we = 1'b1; waddr = AW'(sp + 32'd3); wdata = x3; end
      EX_WR4: begin we = 1'b1; waddr = AW'(sp + 32'd4); wdata = x4; end
      EX_TOP: raddr = AW'(sp);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EX_CLEAR;
      clr_addr <= '0;
      pc <= 32'd0; fb <= 32'd0; sp <= 32'hFFFF_FFFF; x3 <= 32'd0; x4 <= 32'd0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == EX_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (res_valid && res_ready) out_full <= 1'b0;
      case (state)
        EX_IDLE: if (q_pop) begin
          cur <= q_data;
          res.put_valid <= 1'b0;
          res.put_value <= 32'd0;
        end
        EX_RD1: begin
          res.status <= st;
          w0 <= 32'd0; w1 <= 32'd0;
        end
        EX_RD2: w0 <= rdata;
        EX_RD3: if (cur.opcode == OP_RTN) w1 <= rdata; else w1 <= rdata;
        EX_RD4: w2 <= rdata;
        EX_CALC: if (cur.operand == OPR_DIV && w0 == 32'd0) res.status <= ST_DIV_ZERO;
        EX_WR: begin
          pc <= pc + 32'd1;
          case (cur.opcode)
            OP_LIT, OP_GET, OP_LOD: sp <= sp + 32'd1;
            OP_STO: sp <= sp - 32'd1;
            OP_OPR: if (cur.operand != OPR_NEG) sp <= sp - 32'd1;
            OP_INT: sp <= sp + cur.operand;
            OP_JMP: pc <= cur.operand;
            OP_JPC: begin
              sp <= sp - 32'd1;
              if (w0 == 32'd0) pc <= cur.operand;
            end
            OP_PUT: begin
              sp <= sp - 32'd1;
              res.put_valid <= 1'b1;
              res.put_value <= w0;
            end
            OP_MVX: begin
              sp <= sp - 32'd1;
              case (cur.index_sel)
                SEL_PC: pc <= w0;
                SEL_FB: fb <= w0;
                SEL_SP: sp <= w0 - 32'd1;
                SEL_X3: x3 <= w0;
                SEL_X4: x4 <= w0;
                default: ;
              endcase
            end
            OP_RTN: begin
              // w0 old frame base, w1 return pc, w2 and rdata the index registers.
              sp <= fb - FRAME_WORDS;
              pc <= w1;
              x3 <= w2;
              x4 <= rdata;
              fb <= w0;
            end
            default: ;
          endcase
        end
        EX_WR4: begin
          fb <= sp + FRAME_WORDS;
          sp <= sp + 32'd4;
          pc <= cur.operand;
        end
        EX_OUT: begin
          res.next_pc   <= pc;
          res.top_value <= ok(sp) ? rdata : 32'd0;
          out_full      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_valid = out_full;
endmodule

FILE: rtl/core/svm_checker.sv
// Port-level checks for the stack machine block, bound to the top level.
// Depends on svm_pkg.
module svm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_put_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_put_value
);
  import svm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_err_noput: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> !out_put_valid)
    else $error("put on failed instruction");

  a_noput_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_put_valid |-> out_put_value == 32'd0)
    else $error("put value without put");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_RANGE)
    else $error("status code out of range");
endmodule

bind stack_vm_instruction_execute_top svm_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_put_valid(out_ch.put_valid), .out_status(out_ch.status),
  .out_put_value(out_ch.put_value)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the stack machine execute block: directed table, then
// random instruction streams, checked against a behavioural predictor in this file.
// Depends on svm_pkg, svm_if and the RTL under rtl/core.
module testbench;
  import svm_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 630;
  localparam int IDLE_LIMIT = 8000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [3:0]  opc;
    logic [2:0]  bsel;
    logic [2:0]  isel;
    logic [31:0] opd;
    logic [31:0] getv;
    bit          fixed;
    result_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  svm_in_if  in_ch ();
  svm_out_if out_ch ();

  stack_vm_instruction_execute_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [31:0] pc_q, fb_q, sp_q, x3_q, x4_q;
  logic [31:0] mem_q [DEPTH];

  result_t pending_results [$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int puts_seen = 0;
  int faults_seen = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;
  row_t dir_rows [$];

  function automatic bit in_stack(logic [31:0] a);
    return a < DEPTH;
  endfunction

  function automatic logic [31:0] reg_of(logic [2:0] sel);
    case (sel)
      SEL_FB: return fb_q;
      SEL_SP: return sp_q;
      SEL_X3: return x3_q;
      SEL_X4: return x4_q;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] alu_result(logic [31:0] op, logic [31:0] a,
                                             logic [31:0] b);
    case (op)
      OPR_ADD: return a + b;
      OPR_SUB: return a - b;
      OPR_MUL: return a * b;
      OPR_DIV: begin
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) return 32'h8000_0000;
        return $signed(a) / $signed(b);
      end
      OPR_EQ: return {31'd0, a == b};
      OPR_NE: return {31'd0, a != b};
      OPR_LT: return {31'd0, $signed(a) < $signed(b)};
      OPR_LE: return {31'd0, $signed(a) <= $signed(b)};
      OPR_GT: return {31'd0, $signed(a) > $signed(b)};
      default: return {31'd0, $signed(a) >= $signed(b)};
    endcase
  endfunction

  // Executes one instruction on the predictor state and returns the expected result.
  function automatic result_t execute_instr(logic [3:0] opc, logic [2:0] bsel,
      logic [2:0] isel, logic [31:0] opd, logic [31:0] getv);
    result_t r;
    logic [31:0] pc, sp, a, v;
    status_t st;
    pc = pc_q + 1;
    sp = sp_q;
    st = ST_OK;
    r.put_valid = 1'b0;
    r.put_value = 32'd0;
    case (opc)
      OP_LIT, OP_GET: begin
        if (!in_stack(sp + 1)) st = ST_RANGE;
        else begin
          sp_q = sp + 1;
          mem_q[sp + 1] = (opc == OP_LIT) ? opd : getv;
        end
      end
      OP_LOD: begin
        a = (bsel == SEL_SP ? sp + 1 : reg_of(bsel)) +
            (isel == SEL_SP ? sp + 1 : reg_of(isel)) + opd;
        if (!in_stack(sp + 1) || !in_stack(a)) st = ST_RANGE;
        else begin
          sp_q = sp + 1;
          mem_q[sp + 1] = mem_q[a];
        end
      end
      OP_STO: begin
        a = reg_of(bsel) + reg_of(isel) + opd;
        if (!in_stack(sp) || !in_stack(a)) st = ST_RANGE;
        else begin
          mem_q[a] = mem_q[sp];
          sp_q = sp - 1;
        end
      end
      OP_MVX: begin
        if (!in_stack(sp)) st = ST_RANGE;
        else begin
          v = mem_q[sp];
          sp_q = sp - 1;
          case (isel)
            SEL_PC: pc = v;
            SEL_FB: fb_q = v;
            SEL_SP: sp_q = v - 1;
            SEL_X3: x3_q = v;
            SEL_X4: x4_q = v;
            default: ;
          endcase
        end
      end
      OP_OPR: begin
        if (opd > OPR_GE) st = ST_ILL_OPR;
        else if (opd == OPR_NEG) begin
          if (!in_stack(sp)) st = ST_RANGE;
          else mem_q[sp] = 32'd0 - mem_q[sp];
        end else if (!in_stack(sp) || !in_stack(sp - 1)) st = ST_RANGE;
        else if (opd == OPR_DIV && mem_q[sp] == 32'd0) st = ST_DIV_ZERO;
        else begin
          mem_q[sp - 1] = alu_result(opd, mem_q[sp - 1], mem_q[sp]);
          sp_q = sp - 1;
        end
      end
      OP_INT: sp_q = sp + opd;
      OP_CAL: begin
        if (!in_stack(sp + 1) || !in_stack(sp + 2) || !in_stack(sp + 3) ||
            !in_stack(sp + 4)) st = ST_RANGE;
        else begin
          mem_q[sp + 1] = fb_q;
          mem_q[sp + 2] = pc;
          mem_q[sp + 3] = x3_q;
          mem_q[sp + 4] = x4_q;
          fb_q = sp + FRAME_WORDS;
          sp_q = sp + 4;
          pc = opd;
        end
      end
      OP_RTN: begin
        a = fb_q;
        if (!in_stack(a - 4) || !in_stack(a - 3) || !in_stack(a - 2) ||
            !in_stack(a - 1)) st = ST_RANGE;
        else begin
          sp_q = a - FRAME_WORDS;
          pc = mem_q[a - 3];
          x3_q = mem_q[a - 2];
          x4_q = mem_q[a - 1];
          fb_q = mem_q[a - 4];
        end
      end
      OP_JMP: pc = opd;
      OP_JPC: begin
        if (!in_stack(sp)) st = ST_RANGE;
        else begin
          if (mem_q[sp] == 32'd0) pc = opd;
          sp_q = sp - 1;
        end
      end
      OP_PUT: begin
        if (!in_stack(sp)) st = ST_RANGE;
        else begin
          r.put_valid = 1'b1;
          r.put_value = mem_q[sp];
          sp_q = sp - 1;
        end
      end
      default: st = ST_ILL_OPC;
    endcase
    if (st == ST_OK) pc_q = pc;
    r.next_pc = pc_q;
    r.top_value = in_stack(sp_q) ? mem_q[sp_q] : 32'd0;
    r.status = st;
    return r;
  endfunction

  function automatic row_t mk_row(logic [3:0] opc, logic [2:0] bsel, logic [2:0] isel,
      logic [31:0] opd, logic [31:0] getv);
    row_t r;
    r.opc = opc;
    r.bsel = bsel;
    r.isel = isel;
    r.opd = opd;
    r.getv = getv;
    r.fixed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t fixed_row(row_t r, logic [31:0] npc, logic [31:0] top,
                                     status_t st);
    r.fixed = 1'b1;
    r.res.next_pc = npc;
    r.res.put_valid = 1'b0;
    r.res.put_value = 32'd0;
    r.res.top_value = top;
    r.res.status = st;
    return r;
  endfunction

  // Builds a random instruction, mostly well formed for the current predictor state.
  function automatic row_t random_row();
    row_t r;
    int pick;
    logic [31:0] base;
    logic [31:0] target;
    r = mk_row(4'($urandom_range(0, 11)), 3'($urandom), 3'($urandom), $urandom,
               $urandom);
    pick = $urandom_range(0, 99);
    if (!in_stack(sp_q) && sp_q != 32'hffff_ffff && pick < 90) begin
      r.opc = OP_INT;
      r.opd = 32'($urandom_range(0, 30)) - sp_q;
      return r;
    end
    if (pick < 2) r.opc = 4'($urandom_range(12, 15));
    else if (pick < 14) r.opc = OP_LIT;
    else if (pick < 22) r.opc = OP_GET;
    else if (pick < 32) r.opc = OP_LOD;
    else if (pick < 40) r.opc = OP_STO;
    else if (pick < 62) r.opc = OP_OPR;
    else if (pick < 70) r.opc = OP_PUT;
    else if (pick < 75) r.opc = OP_JPC;
    else if (pick < 78) r.opc = OP_JMP;
    else if (pick < 84) r.opc = OP_INT;
    else if (pick < 90) r.opc = OP_CAL;
    else if (pick < 95) r.opc = OP_RTN;
    else r.opc = OP_MVX;
    case (r.opc)
      OP_LOD, OP_STO: begin
        if ($urandom_range(0, 9) != 0) begin
          target = 32'($urandom_range(0, 60));
          if (r.opc == OP_LOD)
            base = (r.bsel == SEL_SP ? sp_q + 1 : reg_of(r.bsel)) +
                   (r.isel == SEL_SP ? sp_q + 1 : reg_of(r.isel));
          else
            base = reg_of(r.bsel) + reg_of(r.isel);
          r.opd = target - base;
        end
      end
      OP_OPR: begin
        if ($urandom_range(0, 19) != 0) r.opd = 32'($urandom_range(0, 10));
      end
      OP_INT: begin
        if ($urandom_range(0, 9) != 0) r.opd = 32'($urandom_range(0, 8)) - 32'd3;
        if (sp_q > 200 && sp_q < DEPTH) r.opd = 32'd0 - 32'($urandom_range(50, 150));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %h, expected %h", received, field, got, want);
    errors++;
  endtask

  task automatic send_row(row_t r);
    result_t want;
    want = execute_instr(r.opc, r.bsel, r.isel, r.opd, r.getv);
    if (r.fixed) want = r.res;
    pending_results.push_back(want);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.opc;
    in_ch.base_sel <= r.bsel;
    in_ch.index_sel <= r.isel;
    in_ch.operand <= r.opd;
    in_ch.get_value <= r.getv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Result checking
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("result %0d: transfer with no instruction outstanding", received);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.next_pc !== want.next_pc) report("next_pc", out_ch.next_pc, want.next_pc);
        if (out_ch.put_valid !== want.put_valid)
          report("put_valid", 32'(out_ch.put_valid), 32'(want.put_valid));
        if (out_ch.put_value !== want.put_value)
          report("put_value", out_ch.put_value, want.put_value);
        if (out_ch.top_value !== want.top_value)
          report("top_value", out_ch.top_value, want.top_value);
        if (out_ch.status !== want.status)
          report("status", 32'(out_ch.status), 32'(want.status));
        if (want.put_valid) puts_seen++;
        if (want.status != ST_OK) faults_seen++;
      end
      received++;
    end
  end

  // Receiver: stall pattern changes after each random span; one long hold-off.
  initial begin
    int mode;
    int span;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      if (!hold_done && received >= 150) begin
        hold_done = 1'b1;
        @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) != 0);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("stack_vm_instruction_execute_top: mismatch");
      $finish;
    end
  end

  initial begin
    row_t r;
    int burst;
    int n;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.base_sel <= '0;
    in_ch.index_sel <= '0;
    in_ch.operand <= '0;
    in_ch.get_value <= '0;
    pc_q = 0;
    fb_q = 0;
    sp_q = 32'hffff_ffff;
    x3_q = 0;
    x4_q = 0;
    foreach (mem_q[i]) mem_q[i] = 32'd0;

    // Directed rows: faults on the empty stack, extremes, division corners, frames.
    dir_rows.push_back(fixed_row(mk_row(OP_PUT, 0, 0, 0, 0), 0, 0, ST_RANGE));
    dir_rows.push_back(fixed_row(mk_row(4'd12, 0, 0, 0, 0), 0, 0, ST_ILL_OPC));
    dir_rows.push_back(fixed_row(mk_row(4'd15, 7, 7, 32'hffff_ffff, 32'hffff_ffff),
                                 0, 0, ST_ILL_OPC));
    dir_rows.push_back(fixed_row(mk_row(OP_LIT, 0, 0, 32'h7fff_ffff, 0), 1,
                                 32'h7fff_ffff, ST_OK));
    dir_rows.push_back(fixed_row(mk_row(OP_LIT, 0, 0, 32'h8000_0000, 0), 2,
                                 32'h8000_0000, ST_OK));
    dir_rows.push_back(fixed_row(mk_row(OP_OPR, 0, 0, 32'd11, 0), 2, 32'h8000_0000,
                                 ST_ILL_OPR));
    dir_rows.push_back(fixed_row(mk_row(OP_OPR, 0, 0, 32'hffff_ffff, 0), 2,
                                 32'h8000_0000, ST_ILL_OPR));
    dir_rows.push_back(mk_row(OP_LIT, 0, 0, 32'hffff_ffff, 0));
    dir_rows.push_back(mk_row(OP_OPR, 0, 0, OPR_DIV, 0));
    dir_rows.push_back(mk_row(OP_LIT, 0, 0, 0, 0));
    dir_rows.push_back(fixed_row(mk_row(OP_OPR, 0, 0, OPR_DIV, 0), 5, 0, ST_DIV_ZERO));
    dir_rows.push_back(mk_row(OP_OPR, 0, 0, OPR_NEG, 0));
    dir_rows.push_back(mk_row(OP_GET, 0, 0, 0, 32'h8000_0000));
    dir_rows.push_back(mk_row(OP_OPR, 0, 0, OPR_MUL, 0));
    dir_rows.push_back(mk_row(OP_GET, 0, 0, 0, 32'h7fff_ffff));
    dir_rows.push_back(mk_row(OP_OPR, 0, 0, OPR_LT, 0));
    dir_rows.push_back(mk_row(OP_LOD, SEL_SP, 6, 32'hffff_fffe, 0));
    dir_rows.push_back(mk_row(OP_STO, 5, 0, 32'd40, 0));
    dir_rows.push_back(mk_row(OP_CAL, 0, 0, 32'd100, 0));
    dir_rows.push_back(mk_row(OP_LIT, 0, 0, 32'd7, 0));
    dir_rows.push_back(mk_row(OP_MVX, 0, SEL_X3, 0, 0));
    dir_rows.push_back(mk_row(OP_RTN, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_JPC, 0, 0, 32'd60, 0));
    dir_rows.push_back(mk_row(OP_JMP, 0, 0, 32'hffff_fff0, 0));
    dir_rows.push_back(mk_row(OP_INT, 0, 0, 32'd3, 0));
    dir_rows.push_back(mk_row(OP_PUT, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_MVX, 0, 7, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n < RANDOM_ITEMS) begin
        r = random_row();
        send_row(r);
        burst--;
        n++;
        if (n == 400) begin
          in_ch.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      if (n > 250 && n < 320) continue;
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d instructions sent, %0d results checked, %0d puts, %0d faults",
             sent, received, puts_seen, faults_seen);
    if (errors == 0) $display("stack_vm_instruction_execute_top: match");
    else $display("stack_vm_instruction_execute_top: mismatch");
    $finish;
  end

endmodule
